// ===== src/lsf_pkg.sv =====
// Shared types, constants and microcode ROM for the LPC synthesis filter.
package lsf_pkg;

   localparam int ORDER  = 10;
   localparam int TAP_W  = (ORDER > 1) ? $clog2(ORDER) : 1;
   localparam int VAL_W  = 24;
   localparam int MEM_W  = 32;
   localparam int PROD_W = VAL_W + MEM_W;
   localparam int SUM_W  = PROD_W - 16 + 1;
   localparam int UPC_W  = 3;

   localparam logic [1:0] MODE_COEF   = 2'd0;
   localparam logic [1:0] MODE_GAIN   = 2'd1;
   localparam logic [1:0] MODE_FILTER = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   localparam logic signed [VAL_W-1:0] OUT_SCALE = 24'sd32767;

   typedef struct packed {
      logic [1:0]              mode;
      logic [3:0]              coef_index;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] speech_sample;
      logic               clipped;
   } rsp_type;

   typedef enum logic [1:0] {A_GAIN, A_COEF_FIRST, A_COEF_NEXT} a_sel_type;
   typedef enum logic {B_SAMPLE, B_OUTPUT} b_sel_type;
   typedef enum logic [1:0] {JMP_NEXT, JMP_TAPS, JMP_FINISH} jmp_type;

   typedef logic [UPC_W-1:0] upc_type;

   localparam upc_type UPC_GAIN  = 3'd0;
   localparam upc_type UPC_SUM   = 3'd1;
   localparam upc_type UPC_FIRST = 3'd2;
   localparam upc_type UPC_TAPS  = 3'd3;
   localparam upc_type UPC_OUT   = 3'd4;

   typedef struct packed {
      logic      mul_en;
      a_sel_type a_sel;
      b_sel_type b_sel;
      logic      y_load;
      logic      z_write;
      jmp_type   jmp;
   } uop_type;

   function automatic uop_type ucode_rom(input upc_type upc);
      uop_type w;
      w = '{mul_en: 1'b0, a_sel: A_GAIN, b_sel: B_SAMPLE,
            y_load: 1'b0, z_write: 1'b0, jmp: JMP_FINISH};
      unique case (upc)
         UPC_GAIN: begin
            w.mul_en = 1'b1;
            w.jmp    = JMP_NEXT;
         end
         UPC_SUM: begin
            w.y_load = 1'b1;
            w.jmp    = JMP_NEXT;
         end
         UPC_FIRST: begin
            w.mul_en = 1'b1;
            w.a_sel  = A_COEF_FIRST;
            w.b_sel  = B_OUTPUT;
            w.jmp    = JMP_NEXT;
         end
         UPC_TAPS: begin
            w.mul_en  = 1'b1;
            w.a_sel   = A_COEF_NEXT;
            w.b_sel   = B_OUTPUT;
            w.z_write = 1'b1;
            w.jmp     = JMP_TAPS;
         end
         default: begin
            w.jmp = JMP_FINISH;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== src/lpc_synthesis_filter.sv =====
// Top level of the LPC all-pole synthesis filter with its microcoded datapath.
// A filter transfer steps the microcode through the gain, sum, first, taps and output steps,
// and the block takes no new request until the result is registered (a stalled output holds it),
// since one shared multiplier steps through the taps.
// Coefficient, gain and clear transfers do not make the block busy and give no result.
// Synchronous reset clears coefficients, gain, filter memory and the busy, microcode and result-valid state.
module lpc_synthesis_filter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lsf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lsf_pkg::rsp_type rsp_data
);

   localparam int TW = lsf_pkg::TAP_W;
   localparam int MW = lsf_pkg::MEM_W;
   localparam int VW = lsf_pkg::VAL_W;
   localparam int PW = lsf_pkg::PROD_W;
   localparam int SW = lsf_pkg::SUM_W;
   localparam int OW = PW - 16;

   localparam logic signed [PW-1:0] TRUNC_BIAS = PW'(65535);
   localparam logic signed [OW-1:0] S16_MAX    = OW'(32767);
   localparam logic signed [OW-1:0] S16_MIN    = -OW'(32768);
   localparam logic signed [SW-1:0] S32_MAX    = SW'(64'sh7FFF_FFFF);
   localparam logic signed [SW-1:0] S32_MIN    = -SW'(64'sh8000_0000);

   logic                   busy_ff, busy_in;
   lsf_pkg::upc_type       upc_ff, upc_in;
   logic [TW-1:0]          tap_ff, tap_in;
   logic signed [VW-1:0]   x_ff, x_in;
   logic signed [VW-1:0]   gain_ff, gain_in;
   logic signed [VW-1:0]   coef_ff [lsf_pkg::ORDER];
   logic signed [VW-1:0]   coef_in [lsf_pkg::ORDER];
   logic signed [MW-1:0]   z_ff [lsf_pkg::ORDER];
   logic signed [MW-1:0]   z_in [lsf_pkg::ORDER];
   logic signed [MW-1:0]   yq_ff, yq_in;
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   lsf_pkg::rsp_type       rsp_ff, rsp_in;

   lsf_pkg::uop_type       uop;
   logic                   accept;
   logic                   last_tap;
   logic [TW:0]            tap_nxt;
   logic signed [VW-1:0]   mul_a;
   logic signed [MW-1:0]   mul_b;
   logic signed [PW-1:0]   product;
   logic signed [OW-1:0]   shifted;
   logic signed [SW-1:0]   y_sum;
   logic signed [MW-1:0]   z_src;
   logic signed [SW-1:0]   z_diff;
   logic signed [PW-1:0]   biased;
   logic signed [OW-1:0]   s_wide;
   lsf_pkg::rsp_type       rsp_next;

   function automatic logic signed [MW-1:0] sat32(input logic signed [SW-1:0] v);
      if (v > S32_MAX) begin
         return MW'(S32_MAX);
      end else if (v < S32_MIN) begin
         return MW'(S32_MIN);
      end
      return v[MW-1:0];
   endfunction

   assign uop      = lsf_pkg::ucode_rom(upc_ff);
   assign accept   = req_valid && !busy_ff;
   assign last_tap = (tap_ff == TW'(lsf_pkg::ORDER - 1));
   assign tap_nxt  = {1'b0, tap_ff} + (TW + 1)'(1);

   always_comb begin
      case (uop.a_sel)
         lsf_pkg::A_GAIN:       mul_a = gain_ff;
         lsf_pkg::A_COEF_FIRST: mul_a = coef_ff[0];
         lsf_pkg::A_COEF_NEXT:  mul_a = last_tap ? lsf_pkg::OUT_SCALE
                                                 : coef_ff[tap_nxt[TW-1:0]];
         default:               mul_a = '0;
      endcase
      case (uop.b_sel)
         lsf_pkg::B_SAMPLE: mul_b = MW'(x_ff);
         default:           mul_b = yq_ff;
      endcase
   end

   assign product = PW'(mul_a) * PW'(mul_b);
   assign shifted = prod_ff[PW-1:16];
   assign y_sum   = SW'(shifted) + SW'(z_ff[0]);
   assign z_src   = last_tap ? '0 : z_ff[tap_nxt[TW-1:0]];
   assign z_diff  = SW'(z_src) - SW'(shifted);
   assign biased  = prod_ff[PW-1] ? (prod_ff + TRUNC_BIAS) : prod_ff;
   assign s_wide  = biased[PW-1:16];

   always_comb begin
      if (s_wide > S16_MAX) begin
         rsp_next.speech_sample = 16'sd32767;
         rsp_next.clipped       = 1'b1;
      end else if (s_wide < S16_MIN) begin
         rsp_next.speech_sample = -16'sd32768;
         rsp_next.clipped       = 1'b1;
      end else begin
         rsp_next.speech_sample = s_wide[15:0];
         rsp_next.clipped       = 1'b0;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      upc_in       = upc_ff;
      tap_in       = tap_ff;
      x_in         = x_ff;
      gain_in      = gain_ff;
      coef_in      = coef_ff;
      z_in         = z_ff;
      yq_in        = yq_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         case (req_data.mode)
            lsf_pkg::MODE_COEF: begin
               if ({1'b0, req_data.coef_index} < 5'(lsf_pkg::ORDER)) begin
                  coef_in[req_data.coef_index[TW-1:0]] = req_data.value;
               end
            end
            lsf_pkg::MODE_GAIN: begin
               gain_in = req_data.value;
            end
            lsf_pkg::MODE_FILTER: begin
               busy_in = 1'b1;
               upc_in  = lsf_pkg::UPC_GAIN;
               x_in    = req_data.value;
            end
            default: begin
               for (int k = 0; k < lsf_pkg::ORDER; k++) begin
                  z_in[k] = '0;
               end
            end
         endcase
      end

      if (busy_ff) begin
         if (uop.mul_en) begin
            prod_in = product;
         end
         if (uop.y_load) begin
            yq_in  = sat32(y_sum);
            tap_in = '0;
         end
         if (uop.z_write) begin
            z_in[tap_ff] = sat32(z_diff);
            tap_in       = tap_nxt[TW-1:0];
         end
         case (uop.jmp)
            lsf_pkg::JMP_NEXT: begin
               upc_in = upc_ff + lsf_pkg::UPC_W'(1);
            end
            lsf_pkg::JMP_TAPS: begin
               if (last_tap) begin
                  upc_in = upc_ff + lsf_pkg::UPC_W'(1);
               end
            end
            default: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = rsp_next;
                  busy_in      = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         upc_ff       <= lsf_pkg::UPC_GAIN;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= '0;
         for (int k = 0; k < lsf_pkg::ORDER; k++) begin
            coef_ff[k] <= '0;
            z_ff[k]    <= '0;
         end
      end else begin
         busy_ff      <= busy_in;
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_ff      <= gain_in;
         coef_ff      <= coef_in;
         z_ff         <= z_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff  <= tap_in;
      x_ff    <= x_in;
      yq_ff   <= yq_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/lsf_checker.sv =====
// Port-level checker for the LPC synthesis filter and its bind statement.
module lsf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input lsf_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lsf_pkg::rsp_type rsp_data
);

   logic req_xfer;

   assign req_xfer = req_valid && !req_stall;

   // A held result keeps its value until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // A filter transfer keeps the input side busy in the next cycle.
   a_filter_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_data.mode == lsf_pkg::MODE_FILTER |=> req_stall)
      else $error("filter transfer did not occupy the block");

   // Loads and clears leave the block idle in the next cycle.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_data.mode != lsf_pkg::MODE_FILTER |=> !req_stall)
      else $error("load or clear left the block busy");

   // Loads and clears never produce a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_data.mode != lsf_pkg::MODE_FILTER && !rsp_valid |=> !rsp_valid)
      else $error("result appeared after a load or clear");

   // Reset leaves the block idle with no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind lpc_synthesis_filter lsf_checker u_lsf_checker (.*);
